// File: rtl/twilight_light_detector_core_macros.svh
// assertion helpers for the twilight detector checker
`ifndef TWILIGHT_LIGHT_DETECTOR_CORE_MACROS_SVH
`define TWILIGHT_LIGHT_DETECTOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TLD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("twilight detector check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define TLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("twilight detector check failed");

`endif

// File: rtl/tld_pkg.sv
package tld_pkg;

  // field widths
  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 4;

  // decision constants
  localparam logic [LEVEL_W-1:0] LOW_LEVEL_LIMIT = 10'd30;
  localparam logic [LEVEL_W-1:0] SMALL_STEP      = 10'd5;
  localparam logic [LEVEL_W-1:0] LARGE_STEP      = 10'd20;
  localparam logic [LEVEL_W-1:0] BAND_HALF       = 10'd50;
  localparam logic [LEVEL_W-1:0] BAND_SPLIT      = 10'd100;
  localparam logic [LEVEL_W-1:0] SUNSET_LEVEL    = 10'd70;
  localparam logic [LEVEL_W-1:0] SUNRISE_LEVEL   = 10'd100;
  localparam logic [LEVEL_W-1:0] BOUNDARY_RESET  = 10'd100;
  localparam logic [TIME_W-1:0]  SUNSET_GAP      = 32'd72000;
  localparam logic [CNT_W-1:0]   DEBOUNCE_MAX    = 4'd9;
  localparam logic [CNT_W-1:0]   FLIP_COUNT_MAX  = 4'd15;
  localparam logic [CNT_W-1:0]   CNT_STEP        = 4'd1;

  // one input item
  typedef struct packed {
    logic [LEVEL_W-1:0] sample;
    logic [TIME_W-1:0]  now_seconds;
    logic               clock_valid;
  } tld_item_t;

  // one result item
  typedef struct packed {
    logic               twilight_flipped;
    logic               is_twilight;
    logic               level_known;
    logic [LEVEL_W-1:0] level;
    logic               report_change;
    logic [CNT_W-1:0]   flip_counter;
    logic               sunset_recorded;
    logic               sunrise_recorded;
    logic [TIME_W-1:0]  sunset_time;
    logic [TIME_W-1:0]  sunrise_time;
  } tld_result_t;

  // detector state carried from item to item
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               level_valid;
    logic               twilight;
    logic [CNT_W-1:0]   flip_count;
    logic               lockout;
    logic [CNT_W-1:0]   dawn_count;
    logic [TIME_W-1:0]  sunset_time;
    logic [TIME_W-1:0]  sunrise_time;
  } tld_state_t;

endpackage

// File: rtl/tld_ifs.sv
// light sample channel
interface tld_in_if;
  logic                         valid;
  logic                         ready;
  logic [tld_pkg::LEVEL_W-1:0]  sample;
  logic [tld_pkg::TIME_W-1:0]   now_seconds;
  logic                         clock_valid;

  modport source (output valid, output sample, output now_seconds, output clock_valid,
                  input ready);
  modport sink (input valid, input sample, input now_seconds, input clock_valid,
                output ready);
endinterface

// result channel
interface tld_out_if;
  logic                         valid;
  logic                         ready;
  logic                         twilight_flipped;
  logic                         is_twilight;
  logic                         level_known;
  logic [tld_pkg::LEVEL_W-1:0]  level;
  logic                         report_change;
  logic [tld_pkg::CNT_W-1:0]    flip_counter;
  logic                         sunset_recorded;
  logic                         sunrise_recorded;
  logic [tld_pkg::TIME_W-1:0]   sunset_time;
  logic [tld_pkg::TIME_W-1:0]   sunrise_time;

  modport source (output valid, output twilight_flipped, output is_twilight,
                  output level_known, output level, output report_change,
                  output flip_counter, output sunset_recorded, output sunrise_recorded,
                  output sunset_time, output sunrise_time, input ready);
  modport sink (input valid, input twilight_flipped, input is_twilight,
                input level_known, input level, input report_change,
                input flip_counter, input sunset_recorded, input sunrise_recorded,
                input sunset_time, input sunrise_time, output ready);
endinterface

// boundary write channel
interface tld_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tld_pkg::LEVEL_W-1:0]  boundary;

  modport source (output valid, output boundary, input ready);
  modport sink (input valid, input boundary, output ready);
endinterface

// File: rtl/tld_in_reg.sv
module tld_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  tld_in_if.sink             in_ch,
  input  logic               advance_i,
  output logic               valid_o,
  output tld_pkg::tld_item_t item_o
);

  logic               valid_q;
  tld_pkg::tld_item_t item_q;
  logic               load;

  // take a new item when empty or when the held one moves on
  assign in_ch.ready = !valid_q || advance_i;
  assign load        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.sample      <= in_ch.sample;
      item_q.now_seconds <= in_ch.now_seconds;
      item_q.clock_valid <= in_ch.clock_valid;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/tld_eval.sv
module tld_eval (
  input  tld_pkg::tld_state_t            state_i,
  input  logic [tld_pkg::LEVEL_W-1:0]    boundary_i,
  input  tld_pkg::tld_item_t             item_i,
  output tld_pkg::tld_state_t            state_o,
  output tld_pkg::tld_result_t           result_o
);

  tld_pkg::tld_state_t             nxt;
  logic [tld_pkg::LEVEL_W-1:0]     diff;
  logic [tld_pkg::LEVEL_W-1:0]     lim;
  logic [tld_pkg::LEVEL_W-1:0]     lo;
  logic [tld_pkg::LEVEL_W:0]       hi;
  logic [tld_pkg::LEVEL_W:0]       lv_ext;
  logic [tld_pkg::TIME_W-1:0]      elapsed;
  logic                            below;
  logic                            past_boundary;
  logic                            change;
  logic                            flipped;
  logic                            sent;
  logic                            set_rec;
  logic                            rise_rec;

  // hysteresis band edges, step size and time since the last sunset
  assign diff    = (state_i.level > item_i.sample) ? state_i.level - item_i.sample
                                                   : item_i.sample - state_i.level;
  assign lim     = (item_i.sample < tld_pkg::LOW_LEVEL_LIMIT) ? tld_pkg::SMALL_STEP
                                                              : tld_pkg::LARGE_STEP;
  assign lo      = (boundary_i < tld_pkg::BAND_SPLIT) ? boundary_i
                                                      : boundary_i - tld_pkg::BAND_HALF;
  assign hi      = {1'b0, boundary_i} + {1'b0, tld_pkg::BAND_HALF};
  assign elapsed = item_i.now_seconds - state_i.sunset_time;

  always_comb begin
    nxt           = state_i;
    change        = 1'b0;
    flipped       = 1'b0;
    sent          = 1'b0;
    set_rec       = 1'b0;
    rise_rec      = 1'b0;
    below         = 1'b0;
    past_boundary = 1'b0;

    // level capture and tracking
    if (!state_i.level_valid) begin
      if (item_i.sample > boundary_i) begin
        nxt.level       = item_i.sample;
        nxt.level_valid = 1'b1;
        change          = 1'b1;
      end
    end else if (diff > lim) begin
      nxt.level = item_i.sample;
      change    = 1'b1;
    end
    lv_ext = {1'b0, nxt.level};

    if (nxt.level_valid) begin
      // schmitt trigger with debounce and lockout
      if (state_i.lockout) begin
        if (nxt.level < lo || lv_ext > hi) begin
          nxt.lockout = 1'b0;
        end
      end else begin
        below = state_i.twilight ? (nxt.level < lo) : (lv_ext < hi);
        if (state_i.twilight != below) begin
          change = 1'b1;
          if (state_i.flip_count != tld_pkg::FLIP_COUNT_MAX) begin
            nxt.flip_count = state_i.flip_count + tld_pkg::CNT_STEP;
          end
          past_boundary = state_i.twilight ? (nxt.level > boundary_i)
                                           : (nxt.level < boundary_i);
          if (nxt.flip_count > tld_pkg::DEBOUNCE_MAX && past_boundary) begin
            nxt.twilight   = nxt.level < boundary_i;
            nxt.lockout    = 1'b1;
            nxt.flip_count = '0;
            flipped        = 1'b1;
          end
        end else begin
          nxt.flip_count = '0;
        end
      end

      // sunset and sunrise time stamps
      if (item_i.clock_valid) begin
        if (nxt.twilight && nxt.level < tld_pkg::SUNSET_LEVEL &&
            (state_i.sunset_time <= state_i.sunrise_time || elapsed > tld_pkg::SUNSET_GAP)) begin
          nxt.sunset_time = item_i.now_seconds;
          sent            = 1'b1;
          set_rec         = 1'b1;
        end
        if (nxt.level > tld_pkg::SUNRISE_LEVEL && state_i.sunrise_time <= nxt.sunset_time) begin
          nxt.dawn_count = state_i.dawn_count + tld_pkg::CNT_STEP;
          if (nxt.dawn_count > tld_pkg::DEBOUNCE_MAX) begin
            nxt.sunrise_time = item_i.now_seconds;
            nxt.dawn_count   = '0;
            sent             = 1'b1;
            rise_rec         = 1'b1;
          end
        end else begin
          nxt.dawn_count = '0;
        end
      end
    end
  end

  // result fields
  assign state_o                   = nxt;
  assign result_o.twilight_flipped = flipped;
  assign result_o.is_twilight      = nxt.twilight;
  assign result_o.level_known      = nxt.level_valid;
  assign result_o.level            = nxt.level_valid ? nxt.level : '0;
  assign result_o.report_change    = change && !sent;
  assign result_o.flip_counter     = nxt.flip_count;
  assign result_o.sunset_recorded  = set_rec;
  assign result_o.sunrise_recorded = rise_rec;
  assign result_o.sunset_time      = nxt.sunset_time;
  assign result_o.sunrise_time     = nxt.sunrise_time;

endmodule

// File: rtl/twilight_light_detector_core.sv
// channel  | dir | handshake     | payload
// in_ch    | in  | valid/ready   | sample, now_seconds, clock_valid
// out_ch   | out | valid/ready   | flip/state flags, level, counter, sun times
// cfg_ch   | in  | valid/ready   | boundary (ready held high)
//
// one item per cycle sustained unless out_ch stalls; a result is offered once its
// item moves from the input register into the result register; detector state sits in
// place and is updated on that move, so the next item sees the new state; a stalled
// result holds; the input register still takes one more item behind it
// reset clears the state, valid flags and sets boundary to 100
module twilight_light_detector_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  tld_in_if.sink   in_ch,
  tld_out_if.source out_ch,
  tld_cfg_if.sink  cfg_ch
);

  logic                         s1_valid;
  tld_pkg::tld_item_t           s1_item;
  logic                         advance;
  logic [tld_pkg::LEVEL_W-1:0]  boundary_q;
  tld_pkg::tld_state_t          state_q;
  tld_pkg::tld_state_t          state_d;
  tld_pkg::tld_result_t         result_d;
  tld_pkg::tld_result_t         out_q;
  logic                         out_valid_q;

  // move the held item into the result register when there is room
  assign advance = s1_valid && (!out_valid_q || out_ch.ready);

  tld_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  tld_eval u_eval (
    .state_i    (state_q),
    .boundary_i (boundary_q),
    .item_i     (s1_item),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  // boundary register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boundary_q <= tld_pkg::BOUNDARY_RESET;
    end else if (cfg_ch.valid) begin
      boundary_q <= cfg_ch.boundary;
    end
  end

  // detector state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign out_ch.valid            = out_valid_q;
  assign out_ch.twilight_flipped = out_q.twilight_flipped;
  assign out_ch.is_twilight      = out_q.is_twilight;
  assign out_ch.level_known      = out_q.level_known;
  assign out_ch.level            = out_q.level;
  assign out_ch.report_change    = out_q.report_change;
  assign out_ch.flip_counter     = out_q.flip_counter;
  assign out_ch.sunset_recorded  = out_q.sunset_recorded;
  assign out_ch.sunrise_recorded = out_q.sunrise_recorded;
  assign out_ch.sunset_time      = out_q.sunset_time;
  assign out_ch.sunrise_time     = out_q.sunrise_time;

endmodule

// File: rtl/tld_checker.sv
`include "twilight_light_detector_core_macros.svh"

module tld_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         twilight_flipped_i,
  input logic                         level_known_i,
  input logic [tld_pkg::CNT_W-1:0]    flip_counter_i,
  input logic                         sunset_recorded_i,
  input logic [tld_pkg::TIME_W-1:0]   sunset_time_i
);

  logic                        known_seen_q;
  logic [tld_pkg::TIME_W-1:0]  prev_sunset_q;
  logic                        out_fire;

  assign out_fire = out_valid_i && out_ready_i;

  // history of delivered items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_seen_q  <= 1'b0;
      prev_sunset_q <= '0;
    end else if (out_fire) begin
      known_seen_q  <= known_seen_q || level_known_i;
      prev_sunset_q <= sunset_time_i;
    end
  end

  // a stalled item stays offered
  `TLD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  // once the level is known it never goes back to unknown
  `TLD_ASSERT_IMPL(a_known_sticky, out_valid_i && known_seen_q, level_known_i)

  // sunset time only moves on an item that records it
  `TLD_ASSERT_IMPL(a_sunset_hold, out_valid_i && !sunset_recorded_i,
                   sunset_time_i == prev_sunset_q)

  // a flip clears the debounce count and needs a known level
  `TLD_ASSERT_IMPL(a_flip_clears, out_valid_i && twilight_flipped_i,
                   flip_counter_i == '0 && level_known_i)

endmodule

bind twilight_light_detector_core tld_checker u_tld_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_ch.valid),
  .out_ready_i        (out_ch.ready),
  .twilight_flipped_i (out_ch.twilight_flipped),
  .level_known_i      (out_ch.level_known),
  .flip_counter_i     (out_ch.flip_counter),
  .sunset_recorded_i  (out_ch.sunset_recorded),
  .sunset_time_i      (out_ch.sunset_time)
);

// File: test/tb_twilight_light_detector_core.sv
// tracks the detector state and keeps the results that accepted samples must produce
class twilight_tracker;
  logic [tld_pkg::LEVEL_W-1:0] boundary;
  tld_pkg::tld_state_t         st;
  tld_pkg::tld_result_t        pending_results[$];
  int                          mismatches;
  int                          checked;
  int                          flips;
  int                          sunsets;
  int                          sunrises;

  function new();
    boundary   = tld_pkg::BOUNDARY_RESET;
    st         = '0;
    mismatches = 0;
    checked    = 0;
    flips      = 0;
    sunsets    = 0;
    sunrises   = 0;
  endfunction

  function void set_boundary(logic [tld_pkg::LEVEL_W-1:0] b);
    boundary = b;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // apply one sample to the tracked state and queue the result it causes
  function void take_sample(tld_pkg::tld_item_t it);
    tld_pkg::tld_result_t       r;
    int unsigned                diff;
    int unsigned                step_lim;
    int unsigned                lo;
    int unsigned                hi;
    int unsigned                lv;
    logic [tld_pkg::TIME_W-1:0] elapsed;
    bit                         change;
    bit                         flipped;
    bit                         sent;
    bit                         set_rec;
    bit                         rise_rec;
    bit                         below;

    change   = 1'b0;
    flipped  = 1'b0;
    sent     = 1'b0;
    set_rec  = 1'b0;
    rise_rec = 1'b0;

    // level capture and tracking
    if (!st.level_valid) begin
      if (it.sample > boundary) begin
        st.level       = it.sample;
        st.level_valid = 1'b1;
        change         = 1'b1;
      end
    end else begin
      diff = (st.level > it.sample) ? int'(st.level) - int'(it.sample)
                                    : int'(it.sample) - int'(st.level);
      step_lim = (it.sample < tld_pkg::LOW_LEVEL_LIMIT) ? int'(tld_pkg::SMALL_STEP)
                                                        : int'(tld_pkg::LARGE_STEP);
      if (diff > step_lim) begin
        st.level = it.sample;
        change   = 1'b1;
      end
    end

    if (st.level_valid) begin
      lv = st.level;
      lo = (boundary < tld_pkg::BAND_SPLIT) ? int'(boundary)
                                            : int'(boundary) - int'(tld_pkg::BAND_HALF);
      hi = int'(boundary) + int'(tld_pkg::BAND_HALF);

      // hysteresis, debounce and lockout
      if (st.lockout) begin
        if (lv < lo || lv > hi) st.lockout = 1'b0;
      end else begin
        below = st.twilight ? (lv < lo) : (lv < hi);
        if (st.twilight != below) begin
          change = 1'b1;
          if (st.flip_count < tld_pkg::FLIP_COUNT_MAX) st.flip_count++;
          if (st.flip_count > tld_pkg::DEBOUNCE_MAX &&
              (st.twilight ? (lv > boundary) : (lv < boundary))) begin
            st.twilight   = (lv < boundary);
            flipped       = 1'b1;
            st.lockout    = 1'b1;
            st.flip_count = '0;
          end
        end else begin
          st.flip_count = '0;
        end
      end

      // sun times, only with a running clock
      if (it.clock_valid) begin
        elapsed = it.now_seconds - st.sunset_time;
        if (st.twilight && lv < tld_pkg::SUNSET_LEVEL &&
            (st.sunset_time <= st.sunrise_time || elapsed > tld_pkg::SUNSET_GAP)) begin
          st.sunset_time = it.now_seconds;
          sent           = 1'b1;
          set_rec        = 1'b1;
        end
        if (lv > tld_pkg::SUNRISE_LEVEL && st.sunrise_time <= st.sunset_time) begin
          st.dawn_count++;
          if (st.dawn_count > tld_pkg::DEBOUNCE_MAX) begin
            st.sunrise_time = it.now_seconds;
            sent            = 1'b1;
            rise_rec        = 1'b1;
            st.dawn_count   = '0;
          end
        end else begin
          st.dawn_count = '0;
        end
      end
    end

    r.twilight_flipped = flipped;
    r.is_twilight      = st.twilight;
    r.level_known      = st.level_valid;
    r.level            = st.level_valid ? st.level : '0;
    r.report_change    = !sent && change;
    r.flip_counter     = st.flip_count;
    r.sunset_recorded  = set_rec;
    r.sunrise_recorded = rise_rec;
    r.sunset_time      = st.sunset_time;
    r.sunrise_time     = st.sunrise_time;
    flips    += flipped;
    sunsets  += set_rec;
    sunrises += rise_rec;
    pending_results.push_back(r);
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                checked, name, got, want));
  endtask

  // compare an accepted result with the oldest expected one
  task check_result(tld_pkg::tld_result_t got);
    tld_pkg::tld_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
      checked++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("twilight_flipped", got.twilight_flipped, want.twilight_flipped);
    compare_field("is_twilight", got.is_twilight, want.is_twilight);
    compare_field("level_known", got.level_known, want.level_known);
    compare_field("level", got.level, want.level);
    compare_field("report_change", got.report_change, want.report_change);
    compare_field("flip_counter", got.flip_counter, want.flip_counter);
    compare_field("sunset_recorded", got.sunset_recorded, want.sunset_recorded);
    compare_field("sunrise_recorded", got.sunrise_recorded, want.sunrise_recorded);
    compare_field("sunset_time", got.sunset_time, want.sunset_time);
    compare_field("sunrise_time", got.sunrise_time, want.sunrise_time);
    checked++;
  endtask
endclass

module tb_twilight_light_detector_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  localparam int NUM_PHASES       = 8;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int CYCLE_LIMIT      = 200000;

  logic clk_i;
  logic rst_ni;

  tld_in_if  in_ch();
  tld_out_if out_ch();
  tld_cfg_if cfg_ch();

  twilight_light_detector_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  twilight_tracker             tracker;
  int                          send_idle_pct;
  int                          recv_stall_pct;
  int                          samples_sent;
  int                          cycles;
  int                          boundary_writes;
  logic [tld_pkg::TIME_W-1:0]  clock_s;
  tld_pkg::tld_result_t        seen_result;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("tb_twilight_light_detector_core: FAIL");
      $finish;
    end
  end

  // result receiver with random stalls
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      seen_result.twilight_flipped = out_ch.twilight_flipped;
      seen_result.is_twilight      = out_ch.is_twilight;
      seen_result.level_known      = out_ch.level_known;
      seen_result.level            = out_ch.level;
      seen_result.report_change    = out_ch.report_change;
      seen_result.flip_counter     = out_ch.flip_counter;
      seen_result.sunset_recorded  = out_ch.sunset_recorded;
      seen_result.sunrise_recorded = out_ch.sunrise_recorded;
      seen_result.sunset_time      = out_ch.sunset_time;
      seen_result.sunrise_time     = out_ch.sunrise_time;
      tracker.check_result(seen_result);
    end
  end

  function automatic logic [tld_pkg::LEVEL_W-1:0] clamp_level(int v);
    if (v < 0) return '0;
    if (v > 1023) return 10'd1023;
    return v[tld_pkg::LEVEL_W-1:0];
  endfunction

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 58;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 58;
      end
      default: begin
        send_idle_pct  = 10;
        recv_stall_pct = 10;
      end
    endcase
  endtask

  // drive one item, called and returning at a falling edge
  task automatic drive_item(tld_pkg::tld_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= it.sample;
    in_ch.now_seconds <= it.now_seconds;
    in_ch.clock_valid <= it.clock_valid;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    tracker.take_sample(it);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic put(int s, logic [tld_pkg::TIME_W-1:0] t, logic c);
    tld_pkg::tld_item_t it;
    it.sample      = clamp_level(s);
    it.now_seconds = t;
    it.clock_valid = c;
    drive_item(it);
  endtask

  // boundary write while the detector is idle
  task automatic write_boundary(logic [tld_pkg::LEVEL_W-1:0] b);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.boundary <= b;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    tracker.set_boundary(b);
    boundary_writes++;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // wait until every expected result is back, then let the pipeline settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // short directed run: unknown level, capture, step limits, a dark flip, a band climb
  task automatic run_directed();
    put(0, 32'd0, 1'b0);
    put(100, 32'd1, 1'b1);
    put(1023, 32'hFFFF_FFFF, 1'b1);
    put(1010, 32'd5, 1'b1);
    put(1002, 32'd10, 1'b0);
    put(25, 32'd20, 1'b1);
    put(20, 32'd30, 1'b1);
    put(19, 32'd40, 1'b1);
    clock_s = 32'd100;
    repeat (10) begin
      clock_s += 32'd600;
      put(19, clock_s, 1'b1);
    end
    repeat (7) begin
      clock_s += 32'd900;
      put(120, clock_s, 1'b1);
    end
  endtask

  // random part: mostly sustained light episodes, some pure noise
  task automatic run_random(int goal);
    int target;
    int jitter;
    int len;
    int b;
    tld_pkg::tld_item_t it;
    while (samples_sent < goal) begin
      if ($urandom_range(99) < 15) begin
        it.sample      = clamp_level(int'($urandom_range(1023)));
        it.now_seconds = $urandom;
        it.clock_valid = 1'($urandom_range(1));
        drive_item(it);
      end else begin
        b = tracker.boundary;
        case ($urandom_range(4))
          0: target = $urandom_range(69);
          1: target = $urandom_range(29);
          2: target = b - 60 + int'($urandom_range(120));
          3: target = b + int'($urandom_range(1023 - b));
          default: target = $urandom_range(1023);
        endcase
        case ($urandom_range(3))
          0: jitter = 0;
          1: jitter = 2;
          2: jitter = 6;
          default: jitter = 25;
        endcase
        len = $urandom_range(24, 1);
        for (int k = 0; k < len && samples_sent < goal; k++) begin
          if ($urandom_range(99) < 5) clock_s += $urandom_range(100000, 60000);
          else clock_s += $urandom_range(20000, 1);
          put(target + int'($urandom_range(2 * jitter)) - jitter, clock_s,
              $urandom_range(99) < 90);
        end
      end
    end
  endtask

  initial begin
    logic [tld_pkg::LEVEL_W-1:0] settings [NUM_PHASES];

    tracker           = new();
    samples_sent      = 0;
    boundary_writes   = 0;
    clock_s           = $urandom;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.sample      = '0;
    in_ch.now_seconds = '0;
    in_ch.clock_valid = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.boundary   = tld_pkg::BOUNDARY_RESET;

    settings[0] = tld_pkg::BOUNDARY_RESET;
    settings[1] = 10'd0;
    settings[2] = 10'd1023;
    settings[3] = 10'd99;
    settings[4] = 10'd100;
    settings[5] = 10'd150;
    settings[6] = clamp_level(int'($urandom_range(1023)));
    settings[7] = 10'd50;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // each phase: new boundary after phase 0, new idle pattern, random samples (directed run first in phase 0)
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) write_boundary(settings[p]);
      set_idle(idle_mode_e'(p % 4));
      if (p == 0) run_directed();
      run_random(samples_sent + RANDOM_PER_PHASE);
      drain();
    end

    $display("covered %0d samples under %0d boundary writes and four idle patterns",
             samples_sent, boundary_writes);
    $display("checked %0d results: %0d flips, %0d sunsets, %0d sunrises",
             tracker.checked, tracker.flips, tracker.sunsets, tracker.sunrises);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb_twilight_light_detector_core: PASS");
    end else begin
      $display("%0d mismatches, %0d results still expected",
               tracker.mismatches, tracker.pending());
      $display("tb_twilight_light_detector_core: FAIL");
    end
    $finish;
  end
endmodule
